// ===== hw/rtl/mono_bitmap_draw_engine_macros.svh =====
// Assertion macros for the drawing engine, used by the pixel store (mbd_store.sv).
`ifndef MONO_BITMAP_DRAW_ENGINE_MACROS_SVH
`define MONO_BITMAP_DRAW_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define MBDE_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("drawing engine check failed (same cycle)");

// Next-cycle implication, disabled while reset is active.
`define MBDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("drawing engine check failed (next cycle)");

`endif

// ===== hw/rtl/mbd_pkg.sv =====
package mbd_pkg;

  localparam int COLUMNS_DEF     = 110;
  localparam int PAGES_DEF       = 14;
  localparam int ANGLE_STEPS_DEF = 240;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  localparam logic [2:0] OP_CLEAR_ALL = 3'd0;
  localparam logic [2:0] OP_CLEAR_BOX = 3'd1;
  localparam logic [2:0] OP_LINE      = 3'd2;
  localparam logic [2:0] OP_RAY       = 3'd3;
  localparam logic [2:0] OP_RING      = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  // Signed pixel coordinate, wide enough for polar points off the bitmap.
  typedef logic signed [9:0] coord_t;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] start_x;
    logic [6:0] start_y;
    logic [6:0] end_x;
    logic [6:0] end_y;
    logic [7:0] angle;
    logic [5:0] radius_from;
    logic [5:0] radius_to;
  } mbd_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       clipped;
  } mbd_out_t;

  // One access to the pixel store.
  typedef struct packed {
    logic       valid;
    logic       set;
    logic       read;
    logic [2:0] bit_sel;
  } px_ctl_t;

endpackage

// ===== hw/rtl/mono_bitmap_draw_engine.sv =====
// Drawing engine for a one-bit bitmap of COLUMNS columns by 8*PAGES rows, kept as column
// bytes in one synchronous memory with one read port and one write port; every command
// returns exactly one result beat. Pixels pass through a read-modify-write pipe at one pixel
// per cycle, with the byte just written forwarded when the next pixel hits the same byte.
// Per command: line draws max(|dx|,|dy|)+1 pixels; clear-box clears width*height pixels,
// none for an empty box; ray reduces an angle beyond the last step by ANGLE_STEPS at a
// time, then draws radius_to-radius_from+1 points, none for an empty ray; ring draws
// ANGLE_STEPS points; read returns one byte; an undefined op only returns its beat;
// clear-all sweeps through the memory (COLUMNS*PAGES bytes, 1540 by default), one byte
// per cycle. After reset the same sweep clears the memory, and no command is accepted
// until it ends. Polar points come from a quarter-wave sine table with two read ports and
// one multiplier per axis, two register stages deep. A new command is taken as soon as
// the previous one has put its result into the output register, even while that result
// beat is still stalled.
module mono_bitmap_draw_engine import mbd_pkg::*; #(
  parameter int COLUMNS     = COLUMNS_DEF,
  parameter int PAGES       = PAGES_DEF,
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mbd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mbd_out_t out_data
);

  localparam int ROWS  = PAGES * 8;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(ANGLE_STEPS);
  localparam int AGW   = (NW > 8) ? NW + 1 : 9;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SWEEP = 8'b0000_0010,
    S_BOX   = 8'b0000_0100,
    S_LINE  = 8'b0000_1000,
    S_MOD   = 8'b0001_0000,
    S_RAY   = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Cursor, far corner or line end, and Bresenham terms.
  logic [6:0]       cx_r, cx_nxt, cy_r, cy_nxt;
  logic [6:0]       xlo_r, xlo_nxt, ylo_r, ylo_nxt;
  logic [6:0]       xend_r, xend_nxt, yend_r, yend_nxt;
  logic [6:0]       dx_r, dx_nxt, dy_r, dy_nxt;
  logic             sxn_r, sxn_nxt, syn_r, syn_nxt;
  logic signed [8:0] err_r, err_nxt;

  // Polar walk: angle (or ring index), current radius, last radius.
  logic [AGW-1:0]   ang_r, ang_nxt;
  logic [5:0]       pr_r, pr_nxt, rend_r, rend_nxt;
  logic             ring_r, ring_nxt;
  logic             rd_op_r, rd_op_nxt;

  logic             clip_r, clip_nxt;
  logic [7:0]       rb_r, rb_nxt;
  logic             out_valid_r, out_valid_nxt;
  mbd_out_t         out_r, out_nxt;

  logic             accept;
  logic             sweep_start, sweep_busy, st_busy, rd_valid;
  logic [7:0]       rd_byte;
  logic             pol_valid, pol_busy;
  coord_t           pol_x, pol_y;

  logic             gen_v, gen_set;
  logic             px_v, px_set, px_read, in_rng;
  coord_t           px_x, px_y;
  px_ctl_t          req;
  logic [AW-1:0]    req_addr;

  logic signed [9:0] e2, e_dy, err_w;

  assign in_stall = (state_r != S_IDLE) || sweep_busy;
  assign accept   = in_valid && !in_stall;
  assign e2       = {err_r, 1'b0};
  assign e_dy     = -$signed({3'b0, dy_r});

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    xlo_nxt       = xlo_r;
    ylo_nxt       = ylo_r;
    xend_nxt      = xend_r;
    yend_nxt      = yend_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sxn_nxt       = sxn_r;
    syn_nxt       = syn_r;
    err_nxt       = err_r;
    ang_nxt       = ang_r;
    pr_nxt        = pr_r;
    rend_nxt      = rend_r;
    ring_nxt      = ring_r;
    rd_op_nxt     = 1'b0;
    clip_nxt      = clip_r;
    rb_nxt        = rb_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    sweep_start   = 1'b0;
    gen_v         = 1'b0;
    gen_set       = 1'b1;
    err_w         = 10'(err_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          clip_nxt = 1'b0;
          rb_nxt   = 8'd0;
          cx_nxt   = in_data.start_x;
          cy_nxt   = in_data.start_y;
          xend_nxt = in_data.end_x;
          yend_nxt = in_data.end_y;
          ang_nxt  = AGW'(in_data.angle);
          pr_nxt   = in_data.radius_from;
          rend_nxt = in_data.radius_to;
          ring_nxt = 1'b0;
          if (in_data.op == OP_CLEAR_ALL) begin
            sweep_start = 1'b1;
            state_nxt   = S_SWEEP;
          end else if (in_data.op == OP_CLEAR_BOX) begin
            // Order each axis; the far corner is exclusive.
            xlo_nxt = (in_data.start_x > in_data.end_x) ? in_data.end_x : in_data.start_x;
            xend_nxt = (in_data.start_x > in_data.end_x) ? in_data.start_x : in_data.end_x;
            ylo_nxt = (in_data.start_y > in_data.end_y) ? in_data.end_y : in_data.start_y;
            yend_nxt = (in_data.start_y > in_data.end_y) ? in_data.start_y : in_data.end_y;
            cx_nxt  = xlo_nxt;
            cy_nxt  = ylo_nxt;
            if (in_data.start_x == in_data.end_x || in_data.start_y == in_data.end_y) begin
              state_nxt = S_DRAIN;
            end else begin
              state_nxt = S_BOX;
            end
          end else if (in_data.op == OP_LINE) begin
            dx_nxt  = (in_data.end_x > in_data.start_x) ? in_data.end_x - in_data.start_x
                                                         : in_data.start_x - in_data.end_x;
            dy_nxt  = (in_data.end_y > in_data.start_y) ? in_data.end_y - in_data.start_y
                                                         : in_data.start_y - in_data.end_y;
            sxn_nxt = !(in_data.start_x < in_data.end_x);
            syn_nxt = !(in_data.start_y < in_data.end_y);
            err_nxt = $signed({2'b0, dx_nxt}) - $signed({2'b0, dy_nxt});
            state_nxt = S_LINE;
          end else if (in_data.op == OP_RAY) begin
            state_nxt = (in_data.radius_from > in_data.radius_to) ? S_DRAIN : S_MOD;
          end else if (in_data.op == OP_RING) begin
            ring_nxt  = 1'b1;
            ang_nxt   = '0;
            state_nxt = S_RAY;
          end else if (in_data.op == OP_READ) begin
            rd_op_nxt = 1'b1;
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SWEEP: begin
        if (!sweep_busy) state_nxt = S_DONE;
      end
      S_BOX: begin
        gen_v   = 1'b1;
        gen_set = 1'b0;
        if (cy_r == yend_r - 7'd1) begin
          cy_nxt = ylo_r;
          if (cx_r == xend_r - 7'd1) begin
            state_nxt = S_DRAIN;
          end else begin
            cx_nxt = cx_r + 7'd1;
          end
        end else begin
          cy_nxt = cy_r + 7'd1;
        end
      end
      S_LINE: begin
        gen_v = 1'b1;
        if (cx_r == xend_r && cy_r == yend_r) begin
          state_nxt = S_DRAIN;
        end else begin
          if (e2 > e_dy) begin
            err_w  = err_w - 10'(dy_r);
            cx_nxt = sxn_r ? cx_r - 7'd1 : cx_r + 7'd1;
          end
          if (e2 < $signed({3'b0, dx_r})) begin
            err_w  = err_w + 10'(dx_r);
            cy_nxt = syn_r ? cy_r - 7'd1 : cy_r + 7'd1;
          end
          err_nxt = 9'(err_w);
        end
      end
      S_MOD: begin
        if (ang_r >= AGW'(ANGLE_STEPS)) begin
          ang_nxt = ang_r - AGW'(ANGLE_STEPS);
        end else begin
          state_nxt = S_RAY;
        end
      end
      S_RAY: begin
        if (ring_r) begin
          if (ang_r == AGW'(ANGLE_STEPS - 1)) state_nxt = S_DRAIN;
          else ang_nxt = ang_r + AGW'(1);
        end else begin
          if (pr_r == rend_r) state_nxt = S_DRAIN;
          else pr_nxt = pr_r + 6'd1;
        end
      end
      S_DRAIN: begin
        // A read is issued in the first drain cycle; wait until its byte has landed.
        if (!pol_busy && !st_busy && !rd_op_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.read_byte = rb_r;
          out_nxt.clipped   = clip_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (rd_valid) rb_nxt = rd_byte;
    if (px_v && !in_rng) clip_nxt = 1'b1;
  end

  // Pixel source: the polar pipe, the box and line walkers, or a read.
  always_comb begin
    px_read = rd_op_r;
    if (pol_valid) begin
      px_v   = 1'b1;
      px_x   = pol_x;
      px_y   = pol_y;
      px_set = 1'b1;
    end else begin
      px_v   = gen_v || rd_op_r;
      px_x   = coord_t'({3'b0, cx_r});
      px_y   = coord_t'({3'b0, cy_r});
      px_set = gen_set;
    end
    in_rng = (px_x >= coord_t'(0)) && (px_x < coord_t'(COLUMNS)) &&
             (px_y >= coord_t'(0)) && (px_y < coord_t'(ROWS));
    req.valid   = px_v && in_rng;
    req.set     = px_set;
    req.read    = px_read;
    req.bit_sel = px_y[2:0];
    req_addr    = AW'(32'(px_x[7:0]) * 32'(PAGES) + 32'(px_y[7:3]));
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    xlo_r  <= xlo_nxt;
    ylo_r  <= ylo_nxt;
    xend_r <= xend_nxt;
    yend_r <= yend_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    sxn_r  <= sxn_nxt;
    syn_r  <= syn_nxt;
    err_r  <= err_nxt;
    ang_r  <= ang_nxt;
    pr_r   <= pr_nxt;
    rend_r <= rend_nxt;
    ring_r <= ring_nxt;
    clip_r <= clip_nxt;
    rb_r   <= rb_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_op_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_op_r     <= rd_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  mbd_polar #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_polar (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (state_r == S_RAY),
    .pt_n      (ang_r[NW-1:0]),
    .pt_r      (ring_r ? rend_r : pr_r),
    .pol_valid (pol_valid),
    .pol_x     (pol_x),
    .pol_y     (pol_y),
    .busy      (pol_busy)
  );

  mbd_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .req_addr    (req_addr),
    .sweep_start (sweep_start),
    .sweep_busy  (sweep_busy),
    .busy        (st_busy),
    .rd_valid    (rd_valid),
    .rd_byte     (rd_byte)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/mbd_polar.sv =====
module mbd_polar import mbd_pkg::*; #(
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF,
  localparam int NW = $clog2(ANGLE_STEPS),
  localparam int PW = $clog2(5 * ANGLE_STEPS),
  localparam int IW = $clog2(ANGLE_STEPS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pt_valid,
  input  logic [NW-1:0] pt_n,
  input  logic [5:0]    pt_r,
  output logic          pol_valid,
  output coord_t        pol_x,
  output coord_t        pol_y,
  output logic          busy
);

  localparam longint unsigned HALF_STEPS_L = 64'(2 * ANGLE_STEPS);
  localparam logic [PW-1:0] FULL = PW'(4 * ANGLE_STEPS);
  localparam logic [PW-1:0] HALF = PW'(2 * ANGLE_STEPS);
  localparam logic [PW-1:0] QUARTER = PW'(ANGLE_STEPS);

  // Quarter-wave sine in Q1.16, evaluated at elaboration only.
  function automatic logic [16:0] quarter_sine(input int unsigned q);
    longint unsigned x, x2, t, s30;
    x   = (PI_Q30 * 64'(q)) / HALF_STEPS_L;
    x2  = (x * x) >> 30;
    t   = Q30_ONE;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s30 = (x * t) >> 30;
    return 17'((s30 + 64'd8192) >> 14);
  endfunction

  // Folds a phase into the quarter table; the top bit is the sign.
  function automatic logic [IW:0] fold(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    logic          neg;
    q = p;
    if (q >= FULL) q = q - FULL;
    neg = (q >= HALF);
    if (neg) q = q - HALF;
    if (q > QUARTER) q = HALF - q;
    return {neg, IW'(q)};
  endfunction

  function automatic coord_t round17(input logic signed [26:0] tv);
    logic [26:0] m;
    logic [26:0] mag;
    m   = tv[26] ? 27'(-tv) : 27'(tv);
    mag = (m + 27'd65536) >> 17;
    return tv[26] ? coord_t'(-$signed(10'(mag))) : coord_t'(10'(mag));
  endfunction

  logic [16:0] rom_w [ANGLE_STEPS+1];
  for (genvar g = 0; g <= ANGLE_STEPS; g++) begin : g_rom
    assign rom_w[g] = quarter_sine(g);
  end

  logic [PW-1:0] ph_s, ph_c;
  logic [IW:0]   f_s, f_c;
  assign ph_s = PW'({pt_n, 2'b10});
  assign ph_c = ph_s + QUARTER;
  assign f_s  = fold(ph_s);
  assign f_c  = fold(ph_c);

  logic        v_a_r, v_b_r;
  logic [16:0] sin_a_r, cos_a_r;
  logic        sneg_a_r, cneg_a_r;
  logic [5:0]  r_a_r;
  logic signed [26:0] tvx_b_r, tvy_b_r;

  always_ff @(posedge clk) begin
    sin_a_r  <= rom_w[f_s[IW-1:0]];
    cos_a_r  <= rom_w[f_c[IW-1:0]];
    sneg_a_r <= f_s[IW];
    cneg_a_r <= f_c[IW];
    r_a_r    <= pt_r;
  end

  logic signed [17:0] sv, cv;
  logic signed [8:0]  kv;
  logic signed [26:0] tvx, tvy;

  always_comb begin
    sv  = sneg_a_r ? -$signed({1'b0, sin_a_r}) : $signed({1'b0, sin_a_r});
    cv  = cneg_a_r ? -$signed({1'b0, cos_a_r}) : $signed({1'b0, cos_a_r});
    kv  = $signed({1'b0, 8'({r_a_r, 1'b0}) + 8'd31});
    tvx = 27'sd7143424 + 27'(sv * kv);
    tvy = 27'sd7143424 + 27'(cv * kv);
  end

  always_ff @(posedge clk) begin
    tvx_b_r <= tvx;
    tvy_b_r <= tvy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
    end else begin
      v_a_r <= pt_valid;
      v_b_r <= v_a_r;
    end
  end

  assign pol_valid = v_b_r;
  assign pol_x     = round17(tvx_b_r);
  assign pol_y     = round17(tvy_b_r);
  assign busy      = v_a_r | v_b_r;

endmodule

// ===== hw/rtl/mbd_store.sv =====
module mbd_store import mbd_pkg::*; #(
  parameter int DEPTH = COLUMNS_DEF * PAGES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  px_ctl_t       req,
  input  logic [AW-1:0] req_addr,
  input  logic          sweep_start,
  output logic          sweep_busy,
  output logic          busy,
  output logic          rd_valid,
  output logic [7:0]    rd_byte
);

`include "mono_bitmap_draw_engine_macros.svh"

  logic [7:0] mem [DEPTH];

  logic          sweep_r;
  logic [AW-1:0] sweep_cnt_r;
  logic          s1_v_r, s1_set_r, s1_read_r, fwd_r;
  logic [2:0]    s1_bit_r;
  logic [AW-1:0] s1_addr_r;
  logic [7:0]    rd_q_r, last_w_r;
  logic [7:0]    base, mask, new_val;
  logic          wr_en;

  // Same-entry back-to-back accesses take the value just written.
  assign base    = fwd_r ? last_w_r : rd_q_r;
  assign mask    = 8'(1) << s1_bit_r;
  assign new_val = s1_set_r ? (base | mask) : (base & ~mask);
  assign wr_en   = s1_v_r && !s1_read_r;

  always_ff @(posedge clk) begin
    rd_q_r <= mem[req_addr];
    if (sweep_r) begin
      mem[sweep_cnt_r] <= 8'd0;
    end else if (wr_en) begin
      mem[s1_addr_r] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    s1_set_r  <= req.set;
    s1_read_r <= req.read;
    s1_bit_r  <= req.bit_sel;
    s1_addr_r <= req_addr;
    last_w_r  <= new_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      s1_v_r      <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      s1_v_r <= req.valid;
      fwd_r  <= wr_en && req.valid && (req_addr == s1_addr_r);
      if (sweep_start) begin
        sweep_r     <= 1'b1;
        sweep_cnt_r <= '0;
      end else if (sweep_r) begin
        if (sweep_cnt_r == AW'(DEPTH - 1)) sweep_r <= 1'b0;
        sweep_cnt_r <= sweep_cnt_r + AW'(1);
      end
    end
  end

  assign sweep_busy = sweep_r;
  assign busy       = s1_v_r;
  assign rd_valid   = s1_v_r && s1_read_r;
  assign rd_byte    = base;

  `MBDE_ASSERT_IMPLIES(a_no_access_in_sweep, clk, rst_n, sweep_r, !req.valid && !s1_v_r)
  `MBDE_ASSERT_IMPLIES(a_sweep_in_range, clk, rst_n, sweep_r, sweep_cnt_r <= AW'(DEPTH - 1))
  `MBDE_ASSERT_NEXT(a_fwd_after_write, clk, rst_n, !(wr_en && req.valid), !fwd_r)

endmodule
